// ===== src/flca_pkg.sv =====
// Shared types and constants for the free list chunk allocator.
package flca_pkg;

    localparam int FREE_ENTRIES_DEF = 64;
    localparam int REGION_BYTES_DEF = 64 * 1024 * 1024;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MAX_REGIONS_DEF  = 4;

    localparam int ADDR_W   = 28;
    localparam int SIZE_W   = 27;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 3;

    localparam logic [CFG_W-1:0] REGIONS_ALLOWED_RST = 3'd4;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REGION,
        S_GIVE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   chunk_addr;
        logic [SIZE_W-1:0]   chunk_size;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic load_new;
        logic take_next;
    } cell_ctrl_t;

endpackage

// ===== src/flca_cell.sv =====
// One free stack entry: loads a pushed chunk or takes its upper neighbor on removal.
module flca_cell (
    input  logic                       clk,
    input  flca_pkg::cell_ctrl_t       ctrl,
    input  flca_pkg::entry_t           new_entry,
    input  flca_pkg::entry_t           next_entry,
    input  logic [flca_pkg::SIZE_W-1:0] req_size,
    output flca_pkg::entry_t           entry,
    output logic                       hit
);

    flca_pkg::entry_t entry_reg;
    flca_pkg::entry_t entry_next;

    // Pick the new content of this entry
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_new)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.take_next)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Flag a chunk large enough for the pending request
    assign hit   = (entry_reg.size >= req_size);
    assign entry = entry_reg;

endmodule

// ===== src/free_list_chunk_allocator_top.sv =====
// Top level of the free list chunk allocator: a chain of stack cells and its sequencer.
// A free request goes from idle to the result state. An allocate request scans the stack
// from the top one entry per cycle, takes a fresh region if no fitting chunk is found,
// hands out the picked chunk in the give state, pushing back any remainder, and ends in
// the result state, which waits until the response register is free. Requests are worked
// on one at a time, and a new request is taken while a response still waits.
module free_list_chunk_allocator_top #(
    parameter int FREE_ENTRIES = flca_pkg::FREE_ENTRIES_DEF,
    parameter int REGION_BYTES = flca_pkg::REGION_BYTES_DEF,
    parameter int HEADER_BYTES = flca_pkg::HEADER_BYTES_DEF,
    parameter int MAX_REGIONS  = flca_pkg::MAX_REGIONS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [flca_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  flca_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output flca_pkg::rsp_t             rsp
);

    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
    localparam int IDX_W = $clog2(FREE_ENTRIES);
    localparam int RU_W  = $clog2(MAX_REGIONS + 1);
    localparam logic [flca_pkg::SIZE_W-1:0] PAYLOAD =
        flca_pkg::SIZE_W'(REGION_BYTES - HEADER_BYTES);
    localparam logic [flca_pkg::ADDR_W-1:0] HDR = flca_pkg::ADDR_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FREE_ENTRIES);

    flca_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [RU_W-1:0]  used_reg, used_next;
    logic [flca_pkg::CFG_W-1:0] allowed_reg, allowed_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    flca_pkg::req_t   req_reg, req_next;
    flca_pkg::entry_t pick_reg, pick_next;
    flca_pkg::rsp_t   res_reg, res_next;
    flca_pkg::rsp_t   rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    flca_pkg::entry_t entries [FREE_ENTRIES];
    logic [FREE_ENTRIES-1:0] hits;
    flca_pkg::cell_ctrl_t ctrls [FREE_ENTRIES];

    logic             push_en;
    flca_pkg::entry_t push_entry;
    logic             remove_en;
    logic             accept;
    logic             rsp_free;
    logic [31:0]      limit;
    logic             region_ok;
    logic [flca_pkg::ADDR_W-1:0] need;
    logic             split;

    assign accept   = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign need     = {1'b0, req_reg.req_size} + HDR;
    assign split    = ({1'b0, pick_reg.size} > need);
    assign limit    = (32'(allowed_reg) > 32'(MAX_REGIONS)) ?
                      32'(MAX_REGIONS) : 32'(allowed_reg);
    assign region_ok = (32'(used_reg) < limit) && (req_reg.req_size <= PAYLOAD) &&
                       (count_reg < FULL_CNT);

    // Build the cell chain
    for (genvar i = 0; i < FREE_ENTRIES; i++)
    begin : g_cell
        flca_pkg::entry_t up_entry;
        if (i == FREE_ENTRIES - 1)
        begin : g_last
            assign up_entry = entries[i];
        end
        else
        begin : g_mid
            assign up_entry = entries[i + 1];
        end

        assign ctrls[i].load_new  = push_en && (count_reg == CNT_W'(i));
        assign ctrls[i].take_next = remove_en && (IDX_W'(i) >= scan_reg);

        flca_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrls[i]),
            .new_entry  (push_entry),
            .next_entry (up_entry),
            .req_size   (req_reg.req_size),
            .entry      (entries[i]),
            .hit        (hits[i])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            flca_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == flca_pkg::REQ_FREE)
                    begin
                        state_next = flca_pkg::S_RESULT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = flca_pkg::S_REGION;
                    end
                    else
                    begin
                        state_next = flca_pkg::S_SCAN;
                    end
                end
            end
            flca_pkg::S_SCAN:
            begin
                if (hits[scan_reg])
                begin
                    state_next = flca_pkg::S_GIVE;
                end
                else if (scan_reg == '0)
                begin
                    state_next = flca_pkg::S_REGION;
                end
            end
            flca_pkg::S_REGION:
            begin
                state_next = region_ok ? flca_pkg::S_GIVE : flca_pkg::S_RESULT;
            end
            flca_pkg::S_GIVE:
            begin
                state_next = flca_pkg::S_RESULT;
            end
            flca_pkg::S_RESULT:
            begin
                if (rsp_free)
                begin
                    state_next = flca_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = flca_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs per state
    always_comb
    begin
        count_next     = count_reg;
        used_next      = used_reg;
        allowed_next   = cfg_we ? cfg_wdata : allowed_reg;
        scan_next      = scan_reg;
        req_next       = req_reg;
        pick_next      = pick_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        push_en        = 1'b0;
        push_entry     = '0;
        remove_en      = 1'b0;
        req_stall      = (state_reg != flca_pkg::S_IDLE);
        unique case (state_reg)
            flca_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next  = req;
                    res_next  = '0;
                    scan_next = IDX_W'(count_reg - CNT_W'(1));
                    if (req.req_type == flca_pkg::REQ_FREE)
                    begin
                        if (count_reg < FULL_CNT)
                        begin
                            push_en           = 1'b1;
                            push_entry.addr   = req.free_addr;
                            push_entry.size   = req.req_size;
                            count_next        = count_reg + CNT_W'(1);
                            res_next.status   = flca_pkg::ST_OK;
                        end
                        else
                        begin
                            res_next.status = flca_pkg::ST_FULL;
                        end
                    end
                end
            end
            flca_pkg::S_SCAN:
            begin
                if (hits[scan_reg])
                begin
                    pick_next  = entries[scan_reg];
                    remove_en  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    scan_next = scan_reg - IDX_W'(1);
                end
            end
            flca_pkg::S_REGION:
            begin
                if (region_ok)
                begin
                    pick_next.addr = flca_pkg::ADDR_W'(32'(used_reg) * 32'(REGION_BYTES));
                    pick_next.size = PAYLOAD;
                    used_next      = used_reg + RU_W'(1);
                end
                else
                begin
                    res_next.status = flca_pkg::ST_NOMEM;
                end
            end
            flca_pkg::S_GIVE:
            begin
                res_next.status     = flca_pkg::ST_OK;
                res_next.chunk_addr = pick_reg.addr;
                res_next.chunk_size = pick_reg.size;
                if (split)
                begin
                    push_en             = 1'b1;
                    push_entry.addr     = pick_reg.addr + need;
                    push_entry.size     = flca_pkg::SIZE_W'({1'b0, pick_reg.size} - need);
                    count_next          = count_reg + CNT_W'(1);
                    res_next.chunk_size = req_reg.req_size;
                end
            end
            flca_pkg::S_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flca_pkg::S_IDLE;
            count_reg     <= '0;
            used_reg      <= '0;
            allowed_reg   <= flca_pkg::REGIONS_ALLOWED_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            allowed_reg   <= allowed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        req_reg  <= req_next;
        pick_reg <= pick_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/flca_checker.sv =====
// Port-level checks for the free list chunk allocator, bound to its top level.
module flca_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input flca_pkg::rsp_t rsp
);

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // A full-stack response carries no chunk
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == flca_pkg::ST_FULL |->
        rsp.chunk_addr == '0 && rsp.chunk_size == '0)
        else $error("full response carries a chunk");

    // A failed allocate carries no chunk
    a_nomem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == flca_pkg::ST_NOMEM |->
        rsp.chunk_addr == '0 && rsp.chunk_size == '0)
        else $error("failed allocate carries a chunk");

    // A request taken while no response is shown is not answered in the cycle after
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
        else $error("response appeared one cycle after request");

endmodule

bind free_list_chunk_allocator_top flca_checker u_flca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the free list chunk allocator: random and directed requests.
module tb;

    localparam int ENTRIES = flca_pkg::FREE_ENTRIES_DEF;
    localparam longint REGION = longint'(flca_pkg::REGION_BYTES_DEF);
    localparam longint HDR = longint'(flca_pkg::HEADER_BYTES_DEF);
    localparam int MAXREG = flca_pkg::MAX_REGIONS_DEF;
    localparam int CYCLE_LIMIT = 900000;

    // Predicts responses from a private copy of the free stack and counts mismatches.
    class alloc_scoreboard;
        logic [flca_pkg::ADDR_W-1:0] stk_addr[ENTRIES];
        logic [flca_pkg::SIZE_W-1:0] stk_size[ENTRIES];
        int depth;
        int regions_used;
        int allowed;
        flca_pkg::rsp_t pending[$];
        int errors;
        int n_ok;
        int n_nomem;
        int n_full;
        int n_split;
        int n_region;

        function void clear();
            depth = 0;
            regions_used = 0;
            allowed = 4;
            errors = 0;
            pending.delete();
        endfunction

        function void push(longint a, longint s);
            if (depth < ENTRIES)
            begin
                stk_addr[depth] = a[flca_pkg::ADDR_W-1:0];
                stk_size[depth] = s[flca_pkg::SIZE_W-1:0];
                depth++;
            end
        endfunction

        // Hand out a chunk, splitting a large remainder back onto the stack.
        function flca_pkg::rsp_t hand_out(longint a, longint s, longint want);
            flca_pkg::rsp_t r;
            r.status = flca_pkg::ST_OK;
            if (s > want + HDR)
            begin
                push(a + want + HDR, s - want - HDR);
                s = want;
                n_split++;
            end
            r.chunk_addr = a[flca_pkg::ADDR_W-1:0];
            r.chunk_size = s[flca_pkg::SIZE_W-1:0];
            return r;
        endfunction

        function void note_request(flca_pkg::req_t q);
            flca_pkg::rsp_t r;
            int lim;
            int hit;
            longint a;
            longint s;
            r = '0;
            r.status = flca_pkg::ST_NOMEM;
            hit = -1;
            if (q.req_type == flca_pkg::REQ_FREE)
            begin
                if (depth >= ENTRIES)
                    r.status = flca_pkg::ST_FULL;
                else
                begin
                    push(q.free_addr, q.req_size);
                    r.status = flca_pkg::ST_OK;
                end
            end
            else
            begin
                for (int i = depth - 1; i >= 0 && hit < 0; i--)
                    if (stk_size[i] >= q.req_size)
                        hit = i;
                if (hit >= 0)
                begin
                    a = stk_addr[hit];
                    s = stk_size[hit];
                    for (int i = hit; i < depth - 1; i++)
                    begin
                        stk_addr[i] = stk_addr[i+1];
                        stk_size[i] = stk_size[i+1];
                    end
                    depth--;
                    r = hand_out(a, s, q.req_size);
                end
                else
                begin
                    lim = (allowed > MAXREG) ? MAXREG : allowed;
                    if (regions_used < lim && longint'(q.req_size) <= REGION - HDR
                        && depth < ENTRIES)
                    begin
                        a = (longint'(regions_used) * REGION) & 64'h0FFFFFFF;
                        regions_used++;
                        n_region++;
                        r = hand_out(a, REGION - HDR, q.req_size);
                    end
                end
            end
            case (r.status)
                flca_pkg::ST_OK: n_ok++;
                flca_pkg::ST_NOMEM: n_nomem++;
                default: n_full++;
            endcase
            pending.push_back(r);
        endfunction

        function void check_response(flca_pkg::rsp_t got);
            flca_pkg::rsp_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected response %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.chunk_addr !== exp.chunk_addr)
            begin
                $error("chunk_addr: expected %h actual %h", exp.chunk_addr, got.chunk_addr);
                errors++;
            end
            if (got.chunk_size !== exp.chunk_size)
            begin
                $error("chunk_size: expected %h actual %h", exp.chunk_size, got.chunk_size);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [flca_pkg::CFG_W-1:0] cfg_wdata;
    logic req_valid;
    logic req_stall;
    flca_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    flca_pkg::rsp_t rsp;

    alloc_scoreboard sb;
    int cycles;
    bit calm;
    bit hold_rsp;
    int sent;

    free_list_chunk_allocator_top DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always #1 clk = ~clk;

    // Count cycles and stop a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Check each accepted response.
    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);

    // Stall the response side in random bursts, or hold it off for a long stretch.
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
                rsp_stall = 1'b1;
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 17);
                rsp_stall = 1'b1;
                repeat (n) @(negedge clk);
                rsp_stall = 1'b0;
            end
            else
                rsp_stall = 1'b0;
        end
    end

    // Offer one request and hold it until accepted.
    task automatic send(flca_pkg::req_kind_t k, logic [flca_pkg::SIZE_W-1:0] sz,
                        logic [flca_pkg::ADDR_W-1:0] a);
        int gap;
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 17);
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.req_type = k;
        req.req_size = sz;
        req.free_addr = a;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(req);
        sent++;
        @(negedge clk);
    endtask

    // Let the block drain, then write the region limit.
    task automatic set_regions(logic [flca_pkg::CFG_W-1:0] v);
        req_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        cfg_wdata = v;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.allowed = v;
    endtask

    function automatic logic [flca_pkg::SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return flca_pkg::SIZE_W'($urandom_range(0, 20));
            1: return flca_pkg::SIZE_W'(67108864 - $urandom_range(0, 40));
            2: return flca_pkg::SIZE_W'($urandom);
            3: return flca_pkg::SIZE_W'($urandom_range(0, 2000000));
            default: return flca_pkg::SIZE_W'($urandom_range(0, 300000));
        endcase
    endfunction

    task automatic random_phase(int n, int free_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < free_pct)
                send(flca_pkg::REQ_FREE, pick_size(), flca_pkg::ADDR_W'($urandom));
            else
                send(flca_pkg::REQ_ALLOC, pick_size(), flca_pkg::ADDR_W'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_valid = 1'b0;
        req = '0;
        calm = 1'b0;
        hold_rsp = 1'b0;
        cycles = 0;
        sent = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: first region, splits, exact fits, oversize, extremes.
        send(flca_pkg::REQ_ALLOC, 27'd100, '0);
        send(flca_pkg::REQ_ALLOC, 27'd0, '0);
        send(flca_pkg::REQ_ALLOC, 27'd67108864 - 27'd16, '0);
        send(flca_pkg::REQ_ALLOC, 27'd67108864, '0);
        send(flca_pkg::REQ_ALLOC, 27'h7FFFFFF, '0);
        send(flca_pkg::REQ_FREE, 27'd64, 28'hFFFFFFF);
        send(flca_pkg::REQ_ALLOC, 27'd64, '0);
        send(flca_pkg::REQ_FREE, 27'd80, 28'hFFFFFF0);
        send(flca_pkg::REQ_ALLOC, 27'd63, '0);
        send(flca_pkg::REQ_FREE, 27'h7FFFFFF, 28'hFFFFFF8);
        send(flca_pkg::REQ_ALLOC, 27'd8, '0);
        send(flca_pkg::REQ_FREE, 27'd0, 28'd0);
        send(flca_pkg::REQ_ALLOC, 27'd0, '0);
        send(flca_pkg::REQ_ALLOC, 27'd67108000, '0);
        send(flca_pkg::REQ_ALLOC, 27'd67108000, '0);
        send(flca_pkg::REQ_ALLOC, 27'd67108000, '0);
        // Fill the stack to overflow with frees.
        for (int i = 0; i < 70; i++)
            send(flca_pkg::REQ_FREE, flca_pkg::SIZE_W'($urandom_range(1, 5000)),
                 flca_pkg::ADDR_W'($urandom));

        // Drain and try region limits 0, 7, 1 and 5, extremes included.
        set_regions(3'd0);
        random_phase(150, 30);
        set_regions(3'd7);
        random_phase(150, 30);
        set_regions(3'd1);
        random_phase(150, 50);
        set_regions(3'd5);
        random_phase(150, 40);

        // Receiver holds off while requests keep coming.
        fork
            random_phase(40, 50);
            begin
                hold_rsp = 1'b1;
                repeat (300) @(negedge clk);
                hold_rsp = 1'b0;
            end
        join

        set_regions(3'd2);
        random_phase(700, 45);
        set_regions(3'd4);
        calm = 1'b1;
        random_phase(500, 45);

        req_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        $display("Sent %0d requests: %0d ok, %0d no memory, %0d stack full.",
                 sent, sb.n_ok, sb.n_nomem, sb.n_full);
        $display("Splits %0d, fresh regions %0d, six region limits tried.",
                 sb.n_split, sb.n_region);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
